// ----- hdl/text_mode_terminal_writer_top_assert.svh -----
// Assertion macros shared by the terminal writer modules.
`ifndef TEXT_MODE_TERMINAL_WRITER_TOP_ASSERT_SVH
`define TEXT_MODE_TERMINAL_WRITER_TOP_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define TMTW_ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define TMTW_ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TMTW_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tmtw_pkg.sv -----
// Shared types and constants of the text-mode terminal writer.
package tmtw_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    // Field widths.
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int POS_W   = 11;
    localparam int ATTR_W  = 8;
    localparam int WORD_W  = 16;

    // Selector codes on the input.
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Character codes with a meaning of their own.
    localparam logic [CHAR_W-1:0] CODE_NULL      = 8'd0;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;

    // Attribute and cell contents after reset.
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [WORD_W-1:0] RESET_WORD = {ATTR_RESET, BLANK_CHAR};

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = 1;
    localparam int CNT_W       = 2;

    // Operation decoded by the front.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAR_W-1:0]  code;
        logic [INDEX_W-1:0] index;
    } cmd_t;

    // Head of the command queue as seen by the back.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    // Back status returned to the front.
    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_status_t;

endpackage

// ----- hdl/tmtw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tmtw_ram
    import tmtw_pkg::*;
#(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = COLUMNS_DEFAULT * ROWS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// ----- hdl/tmtw_front.sv -----
// Front of the terminal writer: accepts input beats, decodes them and queues commands.
`include "text_mode_terminal_writer_top_assert.svh"

module tmtw_front
    import tmtw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FUNC_W-1:0]  func,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic [INDEX_W-1:0] cell_index,
    output head_t              head,
    input  back_status_t       status
);

    cmd_t             q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             accept;
    cmd_t             cmd_in;

    // Decode the input beat into a command.
    always_comb
    begin
        cmd_in.code  = char_code;
        cmd_in.index = cell_index;
        unique case (func)
            FUNC_PUT:
            begin
                if (char_code == CODE_NULL)
                begin
                    cmd_in.op = OP_NOP;
                end
                else if (char_code == CODE_NEWLINE)
                begin
                    cmd_in.op = OP_NEWLINE;
                end
                else if (char_code == CODE_BACKSPACE)
                begin
                    cmd_in.op = OP_BACKSPACE;
                end
                else
                begin
                    cmd_in.op = OP_PUT;
                end
            end
            FUNC_CLEAR: cmd_in.op = OP_CLEAR;
            FUNC_READ:  cmd_in.op = OP_READ;
            default:    cmd_in.op = OP_NOP;
        endcase
    end

    // Stall while the queue is full or the screen store is still being initialized.
    assign in_stall = (count_reg == CNT_W'(QUEUE_DEPTH)) || status.init_busy;
    assign accept   = in_valid && !in_stall;

    // Queue head toward the back.
    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = accept ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = status.pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        unique case ({accept, status.pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    `TMTW_ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, status.pop, count_reg != '0, "pop from an empty command queue")
    `TMTW_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH), "command queue count beyond its depth")
    `TMTW_ASSERT_IMPLIES(a_no_push_full, clk, rst_n, accept, count_reg != CNT_W'(QUEUE_DEPTH), "beat taken into a full queue")

endmodule

// ----- hdl/tmtw_back.sv -----
// Back of the terminal writer: executes commands on the screen store and the cursor.
`include "text_mode_terminal_writer_top_assert.svh"

module tmtw_back
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  head_t             head,
    output back_status_t      status,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ATTR_W-1:0] text_attribute,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [POS_W-1:0]  cursor_pos,
    output logic [WORD_W-1:0] cell_word,
    output logic              scrolled
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = (AW > POS_W) ? AW : POS_W;
    localparam int IW    = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W;

    localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
    localparam logic [AW-1:0] MOVE_LAST   = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] BLANK_FIRST = AW'(CELLS - COLUMNS);
    localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_MOVE,
        S_BLANK,
        S_FILL
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [AW-1:0]     cnt_reg;
    logic [AW-1:0]     cnt_next;
    logic [RW-1:0]     row_reg;
    logic [RW-1:0]     row_next;
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [AW-1:0]     base_reg;
    logic [AW-1:0]     base_next;
    logic [ATTR_W-1:0] attr_reg;
    logic [ATTR_W-1:0] attr_next;
    logic              oob_reg;
    logic              oob_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [POS_W-1:0]  cursor_pos_reg;
    logic [POS_W-1:0]  cursor_pos_next;
    logic [WORD_W-1:0] cell_word_reg;
    logic [WORD_W-1:0] cell_word_next;
    logic              scrolled_reg;
    logic              scrolled_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic              slot_free;
    logic              pop;
    logic              emit;
    logic              bs_write;
    logic              scroll_flag;
    logic [WORD_W-1:0] word_out;
    logic [WORD_W-1:0] blank_word;
    logic [AW-1:0]     cur_pos;
    logic [AW-1:0]     pos_sum;
    logic [AW:0]       move_sum;
    logic [IW-1:0]     idx_ext;

    tmtw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign blank_word = {attr_reg, BLANK_CHAR};
    assign cur_pos    = base_reg + AW'(col_reg);
    assign move_sum   = {1'b0, cnt_reg} + (AW + 1)'(COLUMNS + 1);
    assign idx_ext    = IW'(head.cmd.index);
    assign slot_free  = !out_valid_reg || !out_stall;

    // The attribute register takes every write; the port never pushes back.
    assign cfg_ready = 1'b1;
    assign attr_next = cfg_valid ? text_attribute : attr_reg;

    // Command sequencer.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        base_next       = base_reg;
        oob_next        = oob_reg;
        out_valid_next  = out_valid_reg && out_stall;
        cursor_pos_next = cursor_pos_reg;
        cell_word_next  = cell_word_reg;
        scrolled_next   = scrolled_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg;
        ram_wdata       = blank_word;
        ram_raddr       = move_sum[AW-1:0];
        pop             = 1'b0;
        emit            = 1'b0;
        bs_write        = 1'b0;
        scroll_flag     = 1'b0;
        word_out        = '0;

        unique case (state_reg)
            // Sweep the store to the reset blank after reset.
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = RESET_WORD;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            // Take the next command once the result register can hold its beat.
            S_IDLE:
            begin
                if (head.valid && slot_free)
                begin
                    pop = 1'b1;
                    unique case (head.cmd.op)
                        OP_PUT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cur_pos;
                            ram_wdata = {attr_reg, head.cmd.code};
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    scroll_flag = 1'b1;
                                end
                                else
                                begin
                                    row_next  = row_reg + RW'(1);
                                    base_next = base_reg + COLS_A;
                                    emit      = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + CW'(1);
                                emit     = 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            col_next = '0;
                            if (row_reg == LAST_ROW)
                            begin
                                scroll_flag = 1'b1;
                            end
                            else
                            begin
                                row_next  = row_reg + RW'(1);
                                base_next = base_reg + COLS_A;
                                emit      = 1'b1;
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - CW'(1);
                            end
                            else if (row_reg != '0)
                            begin
                                row_next  = row_reg - RW'(1);
                                base_next = base_reg - COLS_A;
                                col_next  = LAST_COL;
                            end
                            ram_we   = 1'b1;
                            bs_write = 1'b1;
                            emit     = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            state_next = S_FILL;
                            cnt_next   = '0;
                        end
                        OP_READ:
                        begin
                            ram_raddr  = AW'(head.cmd.index);
                            oob_next   = !(idx_ext < IW'(CELLS));
                            state_next = S_READ;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                    // Scrolling starts by reading the second row.
                    if (scroll_flag)
                    begin
                        state_next = S_MOVE;
                        cnt_next   = '0;
                        ram_raddr  = COLS_A;
                    end
                end
            end

            // Read data is back in the cycle after the address.
            S_READ:
            begin
                word_out   = oob_reg ? '0 : ram_rdata;
                emit       = 1'b1;
                state_next = S_IDLE;
            end

            // Copy each cell from one row below, reading one cell ahead.
            S_MOVE:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (cnt_reg == MOVE_LAST)
                begin
                    state_next = S_BLANK;
                    cnt_next   = BLANK_FIRST;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            // Blank the bottom row after a scroll.
            S_BLANK:
            begin
                ram_we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next  = S_IDLE;
                    cnt_next    = '0;
                    scroll_flag = 1'b1;
                    emit        = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            // Clear the whole screen and home the cursor.
            S_FILL:
            begin
                ram_we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                    row_next   = '0;
                    col_next   = '0;
                    base_next  = '0;
                    emit       = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Linear cursor position after this command.
        pos_sum = base_next + AW'(col_next);
        if (bs_write)
        begin
            ram_waddr = pos_sum;
        end

        // Load the result beat.
        if (emit)
        begin
            out_valid_next  = 1'b1;
            cursor_pos_next = POS_W'(PW'(pos_sum));
            cell_word_next  = word_out;
            scrolled_next   = scroll_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            base_reg       <= '0;
            attr_reg       <= ATTR_RESET;
            oob_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            cursor_pos_reg <= '0;
            cell_word_reg  <= '0;
            scrolled_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            base_reg       <= base_next;
            attr_reg       <= attr_next;
            oob_reg        <= oob_next;
            out_valid_reg  <= out_valid_next;
            cursor_pos_reg <= cursor_pos_next;
            cell_word_reg  <= cell_word_next;
            scrolled_reg   <= scrolled_next;
        end
    end

    assign status.pop       = pop;
    assign status.init_busy = (state_reg == S_INIT);

    assign out_valid  = out_valid_reg;
    assign cursor_pos = cursor_pos_reg;
    assign cell_word  = cell_word_reg;
    assign scrolled   = scrolled_reg;

    `TMTW_ASSERT_ALWAYS(a_cursor_on_screen, clk, rst_n, (row_reg <= LAST_ROW) && (col_reg <= LAST_COL), "cursor outside the screen")
    `TMTW_ASSERT_ALWAYS(a_row_base, clk, rst_n, 32'(base_reg) == 32'(row_reg) * 32'(COLUMNS), "row base out of step with the cursor row")
    `TMTW_ASSERT_ALWAYS(a_no_overwrite, clk, rst_n, !(emit && out_valid_reg && out_stall), "result loaded over a stalled beat")
    `TMTW_ASSERT_NEXT(a_scroll_end, clk, rst_n, (state_reg == S_BLANK) && (cnt_reg == LAST_CELL), (row_reg == LAST_ROW) && (col_reg == '0) && scrolled_reg && out_valid_reg, "scroll did not end on the bottom row")

endmodule

// ----- hdl/text_mode_terminal_writer_top.sv -----
// Top level of the text-mode terminal writer.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_stall    func, char_code, cell_index
//   result    out_valid / out_stall  cursor_pos, cell_word, scrolled
//   config    cfg_valid / cfg_ready  text_attribute
//
// Put, newline, backspace and ignored codes finish in the IDLE state of the back unless
// they scroll; a read goes on through the READ state. A clear or a scroll walks the screen
// store one cell a cycle, limited by the single write port of the store.
// After reset the store is swept to blanks; input beats stall until the sweep is done,
// configuration writes are taken throughout.
// A two-entry command queue lets input beats arrive while the back is busy or its
// result beat is stalled; the back waits for a free result register before each command.
module text_mode_terminal_writer_top
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FUNC_W-1:0]  func,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic [INDEX_W-1:0] cell_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [POS_W-1:0]   cursor_pos,
    output logic [WORD_W-1:0]  cell_word,
    output logic               scrolled,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ATTR_W-1:0]  text_attribute
);

    head_t        head;
    back_status_t status;

    // Accept and decode input beats.
    tmtw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .char_code  (char_code),
        .cell_index (cell_index),
        .head       (head),
        .status     (status)
    );

    // Execute commands on the screen store.
    tmtw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .text_attribute (text_attribute),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_pos     (cursor_pos),
        .cell_word      (cell_word),
        .scrolled       (scrolled)
    );

endmodule
